### rtl/fdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpc_pkg: shared types and constants
// Limits, codes and divider handshake types for the fractional divider
// parameter calculator.
// ----------------------------------------------------------------------------
package fdpc_pkg;

  // Datapath width of the shared divider
  localparam int DIV_W   = 32;
  localparam int CNT_W   = $clog2(DIV_W);

  // Widest allowed reduced denominator
  localparam int DEN_BITS = 20;
  localparam logic [DIV_W-1:0] DEN_MAX = DIV_W'((64'd1 << DEN_BITS) - 64'd1);

  // Request modes
  localparam logic [1:0] CMD_PLL  = 2'd0;
  localparam logic [1:0] CMD_FRAC = 2'd1;
  localparam logic [1:0] CMD_EVEN = 2'd2;

  // Frequency windows in hertz
  localparam logic [DIV_W-1:0] PLL_FMIN = 32'd600000000;
  localparam logic [DIV_W-1:0] PLL_FMAX = 32'd900000000;
  localparam logic [DIV_W-1:0] OUT_FMIN = 32'd666666;
  localparam logic [DIV_W-1:0] OUT_FMAX = 32'd200000000;

  // Integer part limits
  localparam logic [DIV_W-1:0] PLL_AMIN  = 32'd15;
  localparam logic [DIV_W-1:0] PLL_AMAX  = 32'd90;
  localparam logic [DIV_W-1:0] FRAC_AMIN = 32'd4;
  localparam logic [DIV_W-1:0] FRAC_AFR  = 32'd8;
  localparam logic [DIV_W-1:0] FRAC_AMAX = 32'd900;
  localparam logic [DIV_W-1:0] FRAC_AFOUR = 32'd4;
  localparam logic [DIV_W-1:0] FRAC_ASIX  = 32'd6;
  localparam logic [DIV_W-1:0] EVEN_AMIN = 32'd6;
  localparam logic [DIV_W-1:0] EVEN_AMAX = 32'd254;

  // Offset removed from P1
  localparam logic [17:0] P1_OFFSET = 18'd512;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FREQ    = 3'd1,
    ST_ZERO_DEN = 3'd2,
    ST_INT     = 3'd3,
    ST_FRAC    = 3'd4,
    ST_DEN     = 3'd5
  } status_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } fdpc_div_sts_t;

endpackage

### rtl/fdpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpc_div: shared restoring divider
// Radix-2 unsigned divider, one quotient bit per cycle; pulses done with
// quotient and remainder held until the next start. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module fdpc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fdpc_pkg::DIV_W-1:0]   dividend_i,
  input  logic [fdpc_pkg::DIV_W-1:0]   divisor_i,
  output fdpc_pkg::fdpc_div_sts_t      sts_o,
  output logic [fdpc_pkg::DIV_W-1:0]   quotient_o,
  output logic [fdpc_pkg::DIV_W-1:0]   remainder_o
);
  import fdpc_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  // Advance one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

`ifndef SYNTHESIS
  // Remainder stays below the divisor while busy
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> rem_q < dvs_q)
    else $error("divider partial remainder out of range");
  // Done follows the last step only
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  // Never started with a zero divisor
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("divider started with zero divisor");
`endif

endmodule

### rtl/fractional_divider_param_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_divider_param_calc: fractional-N divider parameter calculator
// Reduces a frequency ratio by Euclid's GCD on one shared 32-step divider,
// checks the mode limits and forms the P1, P2 and P3 divider parameters.
// ----------------------------------------------------------------------------
// Sequencing: a request runs up to E + 4 divides, where E is the number of
//   Euclid remainder steps after the first (at most ~46); a frequency or zero
//   denominator reject skips the divider. One request at a time: the input
//   stalls until the result is staged in the output register.
// Reset: asynchronous, clears the sequencer, divider control and out valid.
module fractional_divider_param_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] target_freq_i,
  input  logic [31:0] source_freq_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [17:0] param_one_o,
  output logic [19:0] param_two_o,
  output logic [19:0] param_three_o,
  output logic        integer_mode_o,
  output logic        divide_by_four_o
);
  import fdpc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_QUOT  = 8'b0000_0010,
    S_GCD   = 8'b0000_0100,
    S_DIVC  = 8'b0000_1000,
    S_DIVB  = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_FRAC  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [DIV_W-1:0] n_q, n_d;
  logic [DIV_W-1:0] a_q, a_d;
  logic [DIV_W-1:0] b_q, b_d;
  logic [DIV_W-1:0] c_q, c_d;
  logic [DIV_W-1:0] x_q, x_d;
  logic [DIV_W-1:0] y_q, y_d;

  // Staged result
  status_e          r_st_q, r_st_d;
  logic [17:0]      r_p1_q, r_p1_d;
  logic [19:0]      r_p2_q, r_p2_d;
  logic [19:0]      r_p3_q, r_p3_d;
  logic             r_im_q, r_im_d;
  logic             r_d4_q, r_d4_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  status_e          o_st_q;
  logic [17:0]      o_p1_q;
  logic [19:0]      o_p2_q;
  logic [19:0]      o_p3_q;
  logic             o_im_q;
  logic             o_d4_q;

  // Divider hookup
  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DIV_W-1:0] div_dvs;
  fdpc_div_sts_t    div_sts;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  logic             in_beat;
  logic             out_free;
  logic             load_out;
  logic             b_zero;
  logic             im_flag;

  fdpc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .sts_o       (div_sts),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_OUT) && out_free;
  assign b_zero     = (b_q == '0);
  assign im_flag    = b_zero && !a_q[0];

  // Sequence the divides and the limit checks
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    n_d       = n_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    x_d       = x_q;
    y_d       = y_q;
    r_st_d    = r_st_q;
    r_p1_d    = r_p1_q;
    r_p2_d    = r_p2_q;
    r_p3_d    = r_p3_q;
    r_im_d    = r_im_q;
    r_d4_d    = r_d4_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          cmd_d  = command_i;
          r_st_d = ST_OK;
          r_p1_d = '0;
          r_p2_d = '0;
          r_p3_d = '0;
          r_im_d = 1'b0;
          r_d4_d = 1'b0;
          if (command_i == CMD_PLL) begin
            n_d = source_freq_i;
            if (target_freq_i < PLL_FMIN || target_freq_i > PLL_FMAX) begin
              r_st_d  = ST_FREQ;
              state_d = S_OUT;
            end else if (source_freq_i == '0) begin
              r_st_d  = ST_ZERO_DEN;
              state_d = S_OUT;
            end else begin
              div_start = 1'b1;
              div_dvd   = target_freq_i;
              div_dvs   = source_freq_i;
              state_d   = S_QUOT;
            end
          end else if (command_i == CMD_FRAC || command_i == CMD_EVEN) begin
            n_d = target_freq_i;
            if (target_freq_i < OUT_FMIN || target_freq_i > OUT_FMAX) begin
              r_st_d  = ST_FREQ;
              state_d = S_OUT;
            end else begin
              div_start = 1'b1;
              div_dvd   = source_freq_i;
              div_dvs   = target_freq_i;
              state_d   = S_QUOT;
            end
          end else begin
            r_st_d  = ST_FREQ;
            state_d = S_OUT;
          end
        end
      end

      // Integer part and first remainder
      S_QUOT: begin
        if (div_sts.done) begin
          a_d = div_quo;
          b_d = div_rem;
          x_d = n_q;
          y_d = div_rem;
          div_start = 1'b1;
          div_dvd   = n_q;
          if (div_rem == '0) begin
            div_dvs = n_q;
            state_d = S_DIVC;
          end else begin
            div_dvs = div_rem;
            state_d = S_GCD;
          end
        end
      end

      // Euclid steps; x holds the divisor once the remainder hits zero
      S_GCD: begin
        if (div_sts.done) begin
          x_d = y_q;
          div_start = 1'b1;
          if (div_rem == '0) begin
            div_dvd = n_q;
            div_dvs = y_q;
            state_d = S_DIVC;
          end else begin
            y_d     = div_rem;
            div_dvd = y_q;
            div_dvs = div_rem;
          end
        end
      end

      // Reduced denominator, then reduced numerator
      S_DIVC: begin
        if (div_sts.done) begin
          c_d       = div_quo;
          div_start = 1'b1;
          div_dvd   = b_q;
          div_dvs   = x_q;
          state_d   = S_DIVB;
        end
      end

      S_DIVB: begin
        if (div_sts.done) begin
          b_d     = div_quo;
          state_d = S_CHECK;
        end
      end

      // Mode limits
      S_CHECK: begin
        state_d = S_OUT;
        if (cmd_q == CMD_EVEN) begin
          if (a_q < EVEN_AMIN || a_q > EVEN_AMAX || a_q[0]) begin
            r_st_d = ST_INT;
          end else begin
            r_p1_d = a_q[17:0];
            r_im_d = im_flag;
          end
        end else if (cmd_q == CMD_PLL && (a_q < PLL_AMIN || a_q > PLL_AMAX)) begin
          r_st_d = ST_INT;
        end else if (cmd_q == CMD_PLL && a_q == PLL_AMAX && !b_zero) begin
          r_st_d = ST_FRAC;
        end else if (cmd_q == CMD_FRAC && (a_q < FRAC_AMIN || a_q > FRAC_AMAX ||
                     (!b_zero && a_q < FRAC_AFR) ||
                     (b_zero && a_q < FRAC_AFR && a_q != FRAC_AFOUR &&
                      a_q != FRAC_ASIX))) begin
          r_st_d = ST_INT;
        end else if (cmd_q == CMD_FRAC && a_q == FRAC_AMAX && !b_zero) begin
          r_st_d = ST_FRAC;
        end else if (c_q > DEN_MAX) begin
          r_st_d = ST_DEN;
        end else begin
          div_start = 1'b1;
          div_dvd   = {b_q[DIV_W-8:0], 7'b0};
          div_dvs   = c_q;
          state_d   = S_FRAC;
        end
      end

      // P1 from the scaled fraction quotient, P2 is its remainder
      S_FRAC: begin
        if (div_sts.done) begin
          r_p1_d  = {a_q[10:0], 7'b0} + div_quo[17:0] - P1_OFFSET;
          r_p2_d  = div_rem[19:0];
          r_p3_d  = c_q[19:0];
          r_im_d  = im_flag;
          r_d4_d  = (cmd_q == CMD_FRAC) && (a_q == FRAC_AFOUR);
          state_d = S_OUT;
        end
      end

      // Hand the result to the output register
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    n_q    <= n_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    x_q    <= x_d;
    y_q    <= y_d;
    r_st_q <= r_st_d;
    r_p1_q <= r_p1_d;
    r_p2_q <= r_p2_d;
    r_p3_q <= r_p3_d;
    r_im_q <= r_im_d;
    r_d4_q <= r_d4_d;
    if (load_out) begin
      o_st_q <= r_st_q;
      o_p1_q <= r_p1_q;
      o_p2_q <= r_p2_q;
      o_p3_q <= r_p3_q;
      o_im_q <= r_im_q;
      o_d4_q <= r_d4_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_st_q;
  assign param_one_o      = o_p1_q;
  assign param_two_o      = o_p2_q;
  assign param_three_o    = o_p3_q;
  assign integer_mode_o   = o_im_q;
  assign divide_by_four_o = o_d4_q;

`ifndef SYNTHESIS
  // Divider is only restarted once idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");
  // Divider results land only in a waiting state
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_QUOT || state_q == S_GCD || state_q == S_DIVC ||
                      state_q == S_DIVB || state_q == S_FRAC))
    else $error("divider result with no consumer");
  // Errors carry all-zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> param_one_o == '0 && param_two_o == '0 &&
      param_three_o == '0 && !integer_mode_o && !divide_by_four_o)
    else $error("error result with nonzero fields");
  // Divide by four implies an even integer ratio
  a_d4_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_four_o |-> integer_mode_o && param_two_o == '0)
    else $error("divide by four without integer mode");
  // Accepted beat leaves idle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q != S_IDLE)
    else $error("accepted beat did not start work");
`endif

endmodule

### bench/fractional_divider_param_calc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_divider_param_calc_tb: self-checking bench for the divider calc
// Drives mode, target and source beats through the valid/stall handshake.
// A scoreboard predicts each divider setting by exact integer arithmetic
// (Euclid reduction, mode limits, P1/P2/P3) and checks every result beat.
// ----------------------------------------------------------------------------
module fractional_divider_param_calc_tb;
  import fdpc_pkg::*;

  localparam int          CLK_PERIOD   = 4;
  localparam int          RESET_CYCLES = 4;
  localparam int          RANDOM_PER_PHASE = 88;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          HOLD_AFTER   = 40;
  localparam int          DRAIN_CYCLES = 1800;
  localparam int          STUCK_LIMIT  = 20000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  // One divider setting as it leaves the block
  typedef struct packed {
    status_e     status;
    logic [17:0] p1;
    logic [19:0] p2;
    logic [19:0] p3;
    logic        int_mode;
    logic        div4;
  } div_setting_t;

  // Tracks requested settings and checks returned ones in order
  class setting_scoreboard;
    div_setting_t setting_q[$];
    int unsigned  requests;
    int unsigned  fails;

    // Reduce the frequency ratio and form the divider setting
    function automatic div_setting_t calc_divider_setting(logic [1:0] cmd,
                                                          logic [31:0] tgt,
                                                          logic [31:0] src);
      div_setting_t res;
      logic [31:0]  num, den, x, y, r, a, b, c, q;
      logic [63:0]  p1, p2;
      res = '0;
      res.status = ST_FREQ;
      if (cmd == CMD_PLL) begin
        if (tgt < PLL_FMIN || tgt > PLL_FMAX) return res;
        num = tgt;
        den = src;
      end else if (cmd == CMD_FRAC || cmd == CMD_EVEN) begin
        if (tgt < OUT_FMIN || tgt > OUT_FMAX) return res;
        num = src;
        den = tgt;
      end else begin
        return res;
      end
      // GCD by repeated remainder
      x = num;
      y = den;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.status = ST_ZERO_DEN;
      if (x == 0) return res;
      num = num / x;
      den = den / x;
      if (den == 0) return res;
      a = num / den;
      b = num % den;
      c = den;
      // Even-integer-only divider ignores the fraction
      if (cmd == CMD_EVEN) begin
        res.status = ST_INT;
        if (a < EVEN_AMIN || a > EVEN_AMAX || a[0]) return res;
        res.status   = ST_OK;
        res.p1       = a[17:0];
        res.int_mode = (b == 0);
        return res;
      end
      if (cmd == CMD_PLL) begin
        res.status = ST_INT;
        if (a < PLL_AMIN || a > PLL_AMAX) return res;
        res.status = ST_FRAC;
        if (a == PLL_AMAX && b != 0) return res;
      end else begin
        res.status = ST_INT;
        if (a < FRAC_AMIN || a > FRAC_AMAX) return res;
        if (b != 0 && a < FRAC_AFR) return res;
        if (b == 0 && a < FRAC_AFR && a != FRAC_AFOUR && a != FRAC_ASIX) return res;
        res.status = ST_FRAC;
        if (a == FRAC_AMAX && b != 0) return res;
      end
      res.status = ST_DEN;
      if (c > DEN_MAX) return res;
      q  = 32'((64'(b) << 7) / 64'(c));
      p1 = (64'(a) << 7) + 64'(q) - 64'(P1_OFFSET);
      p2 = (64'(b) << 7) - 64'(c) * 64'(q);
      res.status   = ST_OK;
      res.p1       = p1[17:0];
      res.p2       = p2[19:0];
      res.p3       = c[19:0];
      res.int_mode = (b == 0) && !a[0];
      res.div4     = (cmd == CMD_FRAC) && (a == FRAC_AFOUR);
      return res;
    endfunction

    function void note_request(logic [1:0] cmd, logic [31:0] tgt, logic [31:0] src);
      setting_q.push_back(calc_divider_setting(cmd, tgt, src));
      requests++;
    endfunction

    function void check_setting(div_setting_t got);
      div_setting_t want;
      if (setting_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: st=%0d p1=%0d p2=%0d p3=%0d im=%0b d4=%0b",
                   $realtime, got.status, got.p1, got.p2, got.p3, got.int_mode, got.div4);
        return;
      end
      want = setting_q.pop_front();
      if (got.status !== want.status || got.p1 !== want.p1 || got.p2 !== want.p2 ||
          got.p3 !== want.p3 || got.int_mode !== want.int_mode || got.div4 !== want.div4) begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("[%0t] mismatch exp: st=%0d p1=%0d p2=%0d p3=%0d im=%0b d4=%0b",
                   $realtime, want.status, want.p1, want.p2, want.p3, want.int_mode,
                   want.div4);
          $display("[%0t]          got: st=%0d p1=%0d p2=%0d p3=%0d im=%0b d4=%0b",
                   $realtime, got.status, got.p1, got.p2, got.p3, got.int_mode, got.div4);
        end
      end
    endfunction

    function int unsigned pending();
      return setting_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [31:0] target_freq_i;
  logic [31:0] source_freq_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [17:0] param_one_o;
  logic [19:0] param_two_o;
  logic [19:0] param_three_o;
  logic        integer_mode_o;
  logic        divide_by_four_o;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  logic        hold_sink;

  setting_scoreboard sb = new();

  fractional_divider_param_calc DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .target_freq_i   (target_freq_i),
    .source_freq_i   (source_freq_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .param_one_o     (param_one_o),
    .param_two_o     (param_two_o),
    .param_three_o   (param_three_o),
    .integer_mode_o  (integer_mode_o),
    .divide_by_four_o(divide_by_four_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Offer one request beat, idling first at the current rate; hold until taken
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] tgt,
                              input logic [31:0] src);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    target_freq_i <= tgt;
    source_freq_i <= src;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, tgt, src);
  endtask

  // Build a request: mostly in-window ratios with chosen integer and fraction
  task automatic send_random_request();
    logic [1:0]      cmd;
    logic [31:0]     tgt, src;
    int unsigned     pick, a, d, k;
    longint unsigned lo, hi, ratio;
    pick = $urandom_range(0, 99);
    cmd  = 2'($urandom_range(0, 2));
    d    = $urandom_range(2, 1000);
    k    = $urandom_range(1, d - 1);
    if (pick < 15) begin
      // raw noise over the full field ranges
      cmd = 2'($urandom);
      tgt = $urandom;
      src = $urandom;
    end else if (cmd == CMD_PLL) begin
      a   = $urandom_range(13, 92);
      lo  = PLL_FMIN / a;
      hi  = PLL_FMAX / a;
      src = $urandom_range(32'(lo), 32'(hi));
      if (pick < 40) ratio = longint'(a) * src;
      else if (pick < 70) begin
        src   = src / d * d;
        ratio = longint'(a) * src + longint'(k) * (src / d);
      end else ratio = longint'(a) * src + $urandom_range(0, src - 1);
      tgt = 32'(ratio);
    end else begin
      if (cmd == CMD_FRAC)
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 9) : $urandom_range(3, 905);
      else
        a = $urandom_range(4, 256);
      hi = 64'hFFFF_FFFF / (a + 1);
      if (hi > OUT_FMAX) hi = OUT_FMAX;
      tgt = $urandom_range(700000, 32'(hi));
      if (pick < 40) ratio = longint'(a) * tgt;
      else if (pick < 70) begin
        tgt   = tgt / d * d;
        ratio = longint'(a) * tgt + longint'(k) * (tgt / d);
      end else ratio = longint'(a) * tgt + $urandom_range(0, tgt - 1);
      src = 32'(ratio);
    end
    send_request(cmd, tgt, src);
  endtask

  // Sink: check accepted result beats, stall at random or during the hold-off
  initial begin : result_sink
    div_setting_t got;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status   = status_e'(status_o);
        got.p1       = param_one_o;
        got.p2       = param_two_o;
        got.p3       = param_three_o;
        got.int_mode = integer_mode_o;
        got.div4     = divide_by_four_o;
        sb.check_setting(got);
      end
      out_stall_i <= hold_sink || ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // Hold off the sink for a long stretch so the block backs up its input
  initial begin : sink_hold
    hold_sink = 1'b0;
    do @(posedge clk_i); while (sb.requests < HOLD_AFTER);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_sink <= 1'b0;
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_PLL;
    target_freq_i = '0;
    source_freq_i = '0;
    src_idle_pct  = 30;
    sink_idle_pct = 75;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: window edges, zero inputs, integer limits per mode
    send_request(CMD_UNUSED, 32'd700000000, 32'd25000000);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_PLL,    32'd0,         32'd0);
    send_request(CMD_PLL,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_PLL,    32'd599999999, 32'd25000000);
    send_request(CMD_PLL,    32'd700000000, 32'd0);
    send_request(CMD_PLL,    32'd800000000, 32'd25000000);
    send_request(CMD_PLL,    32'd800000000, 32'd27000000);
    send_request(CMD_PLL,    32'd900000000, 32'd10000000);
    send_request(CMD_PLL,    32'd900000000, 32'd9999999);
    send_request(CMD_PLL,    32'd600000000, 32'd50000000);
    send_request(CMD_PLL,    32'd700000001, 32'd25000003);
    send_request(CMD_FRAC,   32'd100000000, 32'd400000000);
    send_request(CMD_FRAC,   32'd100000000, 32'd600000000);
    send_request(CMD_FRAC,   32'd100000000, 32'd500000000);
    send_request(CMD_FRAC,   32'd100000000, 32'd750000000);
    send_request(CMD_FRAC,   32'd100000000, 32'd850000000);
    send_request(CMD_FRAC,   32'd1000000,   32'd900000000);
    send_request(CMD_FRAC,   32'd1000000,   32'd900000001);
    send_request(CMD_FRAC,   32'd666666,    32'd0);
    send_request(CMD_FRAC,   32'd200000001, 32'd800000000);
    send_request(CMD_FRAC,   32'd200000000, 32'hFFFF_FFFF);
    send_request(CMD_EVEN,   32'd100000000, 32'd850000000);
    send_request(CMD_EVEN,   32'd100000000, 32'd700000000);
    send_request(CMD_EVEN,   32'd1000000,   32'd254000000);
    send_request(CMD_EVEN,   32'd1000000,   32'd256000000);
    send_request(CMD_EVEN,   32'd666665,    32'd6000000);

    // Random phases: sender idles less, then sink idles less, then no idling
    repeat (RANDOM_PER_PHASE) send_random_request();
    src_idle_pct  = 75;
    sink_idle_pct = 30;
    repeat (RANDOM_PER_PHASE) send_random_request();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_request();
    in_valid_i <= 1'b0;

    // Drain outstanding settings, then watch for stray beats
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
